### src/density_viscosity_face_ratio_macros.svh
// Assertion helpers for the RTL.
`ifndef DENSITY_VISCOSITY_FACE_RATIO_MACROS_SVH
`define DENSITY_VISCOSITY_FACE_RATIO_MACROS_SVH

// Plain implication checked on every rising clock edge outside reset.
`define DVFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked after the trigger, delayed by n.
`define DVFR_ASSERT_DELAY(label, trig, n, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (trig) |-> ##n (cons)) else $error(msg);

`endif

### src/dvfr_pkg.sv
package dvfr_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               near_active;
    logic               far_active;
    logic               head_bc;
    logic signed [31:0] near_salinity;
    logic signed [31:0] near_temp;
    logic signed [31:0] far_salinity;
    logic signed [31:0] far_temp;
  } dvfr_in_t;

  typedef struct packed {
    logic signed [31:0] rho_ratio;
    logic signed [31:0] visc_ratio;
    logic               denom_error;
  } dvfr_out_t;

  // Face kinds.
  localparam logic [1:0] REQ_PAIR = 2'd0;
  localparam logic [1:0] REQ_LOW  = 2'd1;
  localparam logic [1:0] REQ_HIGH = 2'd2;
  localparam logic [1:0] REQ_TOP  = 2'd3;

  // How a face combines its flanks.
  localparam logic [1:0] MODE_ONE  = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_FAR  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_BETA_S  = 3'd0;
  localparam logic [2:0] REG_BETA_SV = 3'd1;
  localparam logic [2:0] REG_BETA_T  = 3'd2;
  localparam logic [2:0] REG_REF_T   = 3'd3;
  localparam logic [2:0] REG_SAL_ON  = 3'd4;
  localparam logic [2:0] REG_THM_ON  = 3'd5;

  localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;

  // Divider: 32 quotient bits of 2^49 / den, four per stage.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 8;
  // 2^49 >> 32: the dividend bits above the quotient window.
  localparam logic [31:0] DIV_REM_INIT = 32'h0002_0000;
  // Denominators up to 2^17 give a reciprocal beyond the Q8.24 range.
  localparam logic [31:0] DEN_BIG_LIM = 32'h0002_0000;

endpackage

### src/density_viscosity_face_ratio.sv
// An accepted item passes stage 0, the product and rounding stages, the divider and the output register.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The reciprocal divider has 8 stages, 4 quotient bits per stage.
// Reset (asynchronous, active low) clears all valid bits and sets the registers
// to their defaults; items in flight are dropped.
`include "density_viscosity_face_ratio_macros.svh"

module density_viscosity_face_ratio
  import dvfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dvfr_in_t    face_i,
  output logic        result_valid_o,
  output dvfr_out_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic signed [31:0] beta_s_q, beta_sv_q, beta_t_q, ref_t_q;
  logic               sal_on_q, thm_on_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_s_q  <= '0;
      beta_sv_q <= '0;
      beta_t_q  <= '0;
      ref_t_q   <= '0;
      sal_on_q  <= 1'b1;
      thm_on_q  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_BETA_S:  beta_s_q  <= pwdata;
        REG_BETA_SV: beta_sv_q <= pwdata;
        REG_BETA_T:  beta_t_q  <= pwdata;
        REG_REF_T:   ref_t_q   <= pwdata;
        REG_SAL_ON:  sal_on_q  <= pwdata[0];
        REG_THM_ON:  thm_on_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BETA_S:  prdata = beta_s_q;
      REG_BETA_SV: prdata = beta_sv_q;
      REG_BETA_T:  prdata = beta_t_q;
      REG_REF_T:   prdata = ref_t_q;
      REG_SAL_ON:  prdata = {31'd0, sal_on_q};
      REG_THM_ON:  prdata = {31'd0, thm_on_q};
      default:     prdata = '0;
    endcase
  end

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    logic signed [31:0] r;
    begin
      if (x > 64'sh0000_0000_7FFF_FFFF) r = SAT_MAX;
      else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [63:0] rnd16(logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Four restoring steps: returns {remainder, quotient bits}.
  function automatic logic [35:0] div4(logic [31:0] rem, logic [30:0] den);
    logic [32:0] r;
    logic [31:0] cur;
    logic [3:0]  q;
    begin
      cur = rem;
      q   = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
        r = {cur, 1'b0};
        if (r >= {2'b00, den}) begin
          r = r - {2'b00, den};
          q[DIV_BITS-1-i] = 1'b1;
        end
        cur = r[31:0];
      end
      return {cur, q};
    end
  endfunction

  // Stage 0: face rule, gated salinity and temperature excess.
  logic               v0_q;
  logic [1:0]         mode0_q;
  logic signed [31:0] s0_q [2];
  logic signed [31:0] dt0_q [2];
  logic [1:0]         mode_d;
  logic signed [31:0] s_d [2];
  logic signed [31:0] dt_d [2];
  logic signed [32:0] diff [2];
  logic signed [31:0] sal_in [2];
  logic signed [31:0] tmp_in [2];

  assign sal_in[0] = face_i.near_salinity;
  assign sal_in[1] = face_i.far_salinity;
  assign tmp_in[0] = face_i.near_temp;
  assign tmp_in[1] = face_i.far_temp;

  always_comb begin
    case (face_i.req_type)
      REQ_PAIR: mode_d = (face_i.near_active && face_i.far_active) ? MODE_MEAN : MODE_ONE;
      REQ_LOW:  mode_d = !face_i.near_active ? MODE_ONE :
                         (face_i.head_bc ? MODE_FAR : MODE_MEAN);
      REQ_HIGH: mode_d = (face_i.near_active && face_i.head_bc) ? MODE_FAR : MODE_ONE;
      REQ_TOP:  mode_d = face_i.near_active ? MODE_MEAN : MODE_ONE;
      default:  mode_d = MODE_ONE;
    endcase
    for (int l = 0; l < 2; l++) begin
      diff[l] = {tmp_in[l][31], tmp_in[l]} - {ref_t_q[31], ref_t_q};
      s_d[l]  = sal_on_q ? sal_in[l] : 32'sd0;
      if (!thm_on_q) dt_d[l] = 32'sd0;
      else if (diff[l][32] != diff[l][31]) dt_d[l] = diff[l][32] ? 32'sh8000_0000 : SAT_MAX;
      else dt_d[l] = diff[l][31:0];
    end
  end

  // Stage 1: products. Stage 2: rounding and saturation.
  logic               v1_q, v2_q;
  logic [1:0]         mode1_q, mode2_q;
  logic signed [63:0] ps1_q [2];
  logic signed [63:0] pt1_q [2];
  logic signed [63:0] pv1_q [2];
  logic signed [31:0] rho2_q [2];
  logic [30:0]        den2_q [2];
  logic               bad2_q [2];
  logic               big2_q [2];
  logic signed [31:0] rho_d [2];
  logic signed [31:0] den_d [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rho_d[l] = sat32(64'(ONE_Q24) + rnd16(ps1_q[l]) - rnd16(pt1_q[l]));
      den_d[l] = sat32(64'(ONE_Q24) + rnd16(pv1_q[l]));
    end
  end

  // Divider stages.
  logic               dv_q   [DIV_STAGES];
  logic [1:0]         dmode_q[DIV_STAGES];
  logic signed [31:0] drho_q [DIV_STAGES][2];
  logic [30:0]        dden_q [DIV_STAGES][2];
  logic [31:0]        drem_q [DIV_STAGES][2];
  logic [31:0]        dquo_q [DIV_STAGES][2];
  logic               dbad_q [DIV_STAGES][2];
  logic               dbig_q [DIV_STAGES][2];
  logic [35:0]        dstep  [DIV_STAGES][2];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) dstep[k][l] = div4(DIV_REM_INIT, den2_q[l]);
        else dstep[k][l] = div4(drem_q[k-1][l], dden_q[k-1][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) dv_q[k] <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      dv_q[0] <= v2_q;
      for (int k = 1; k < DIV_STAGES; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mode0_q <= mode_d;
    mode1_q <= mode0_q;
    mode2_q <= mode1_q;
    dmode_q[0] <= mode2_q;
    for (int k = 1; k < DIV_STAGES; k++) dmode_q[k] <= dmode_q[k-1];
    for (int l = 0; l < 2; l++) begin
      s0_q[l]  <= s_d[l];
      dt0_q[l] <= dt_d[l];
      ps1_q[l] <= beta_s_q * s0_q[l];
      pt1_q[l] <= beta_t_q * dt0_q[l];
      pv1_q[l] <= beta_sv_q * s0_q[l];
      rho2_q[l] <= rho_d[l];
      den2_q[l] <= den_d[l][30:0];
      bad2_q[l] <= den_d[l][31] || (den_d[l] == 32'sd0);
      big2_q[l] <= $unsigned(den_d[l]) <= DEN_BIG_LIM;
      drho_q[0][l] <= rho2_q[l];
      dden_q[0][l] <= den2_q[l];
      dbad_q[0][l] <= bad2_q[l];
      dbig_q[0][l] <= big2_q[l];
      drem_q[0][l] <= dstep[0][l][35:4];
      dquo_q[0][l] <= {28'd0, dstep[0][l][3:0]};
      for (int k = 1; k < DIV_STAGES; k++) begin
        drho_q[k][l] <= drho_q[k-1][l];
        dden_q[k][l] <= dden_q[k-1][l];
        dbad_q[k][l] <= dbad_q[k-1][l];
        dbig_q[k][l] <= dbig_q[k-1][l];
        drem_q[k][l] <= dstep[k][l][35:4];
        dquo_q[k][l] <= {dquo_q[k-1][l][27:0], dstep[k][l][3:0]};
      end
    end
  end

  // Output stage: round the reciprocal, saturate, combine flanks.
  localparam int LAST = DIV_STAGES - 1;
  logic [32:0]        rinc [2];
  logic signed [31:0] visc [2];
  logic signed [32:0] rho_sum, visc_sum;
  dvfr_out_t          res_d, res_q;
  logic               res_v_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rinc[l] = {1'b0, dquo_q[LAST][l]} + 33'd1;
      visc[l] = (dbad_q[LAST][l] || dbig_q[LAST][l] || rinc[l][32]) ?
                SAT_MAX : $signed(rinc[l][32:1]);
    end
    rho_sum  = {drho_q[LAST][0][31], drho_q[LAST][0]} +
               {drho_q[LAST][1][31], drho_q[LAST][1]} + 33'sd1;
    visc_sum = {visc[0][31], visc[0]} + {visc[1][31], visc[1]} + 33'sd1;
    case (dmode_q[LAST])
      MODE_MEAN: begin
        res_d.rho_ratio   = rho_sum[32:1];
        res_d.denom_error = dbad_q[LAST][0] || dbad_q[LAST][1];
        res_d.visc_ratio  = res_d.denom_error ? SAT_MAX : visc_sum[32:1];
      end
      MODE_FAR: begin
        res_d.rho_ratio   = drho_q[LAST][1];
        res_d.denom_error = dbad_q[LAST][1];
        res_d.visc_ratio  = visc[1];
      end
      default: begin
        res_d.rho_ratio   = ONE_Q24;
        res_d.visc_ratio  = ONE_Q24;
        res_d.denom_error = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= dv_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  `DVFR_ASSERT_DELAY(a_latency, start && !busy, 12, result_valid_o, "item lost in pipeline")
  `DVFR_ASSERT(a_err_sat, result_valid_o && result_o.denom_error |-> result_o.visc_ratio == SAT_MAX, "denom_error without saturated viscosity")
  `DVFR_ASSERT(a_visc_pos, result_valid_o |-> result_o.visc_ratio > 32'sd0, "viscosity ratio not positive")

endmodule

### tb/testbench.sv
module testbench;
  import dvfr_pkg::*;

  localparam int LATENCY     = 11;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  dvfr_in_t    face_i;
  logic        result_valid_o;
  dvfr_out_t   result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  density_viscosity_face_ratio DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .face_i         (face_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Local copy of the register file.
  longint cfg_beta_s;
  longint cfg_beta_sv;
  longint cfg_beta_t;
  longint cfg_ref_t;
  bit     cfg_sal_on;
  bit     cfg_thm_on;

  dvfr_out_t expected_ratios[$];
  int        fail_count;
  int        cycle_count;
  bit        burst_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** density_viscosity_face_ratio: FAILED **");
      $finish;
    end
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q8.24 coefficient times Q16.16 scalar, rounded back to Q8.24.
  function automatic longint scale_q24(longint coef, longint val);
    return (coef * val + 64'sd32768) >>> 16;
  endfunction

  function automatic void flank_ratios(input logic signed [31:0] sal,
                                       input logic signed [31:0] temp,
                                       output longint rho, output longint visc,
                                       output bit bad);
    longint s;
    longint dt;
    longint den;
    longint q;
    longint r;
    s   = cfg_sal_on ? longint'(sal) : 0;
    dt  = cfg_thm_on ? sat32(longint'(temp) - cfg_ref_t) : 0;
    rho = sat32(longint'(ONE_Q24) + scale_q24(cfg_beta_s, s) - scale_q24(cfg_beta_t, dt));
    den = sat32(longint'(ONE_Q24) + scale_q24(cfg_beta_sv, s));
    if (den <= 0) begin
      visc = longint'(SAT_MAX);
      bad  = 1'b1;
    end else begin
      q = (64'sd1 <<< 48) / den;
      r = (64'sd1 <<< 48) % den;
      if (2 * r >= den) q++;
      visc = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
      bad  = 1'b0;
    end
  endfunction

  function automatic dvfr_out_t predict_face_ratio(dvfr_in_t f);
    longint    nr, nv, fr, fv;
    bit        nb, fb;
    logic [1:0] mode;
    dvfr_out_t o;
    flank_ratios(f.near_salinity, f.near_temp, nr, nv, nb);
    flank_ratios(f.far_salinity, f.far_temp, fr, fv, fb);
    case (f.req_type)
      REQ_PAIR: mode = (f.near_active && f.far_active) ? MODE_MEAN : MODE_ONE;
      REQ_LOW:  mode = f.near_active ? (f.head_bc ? MODE_FAR : MODE_MEAN) : MODE_ONE;
      REQ_HIGH: mode = (f.near_active && f.head_bc) ? MODE_FAR : MODE_ONE;
      default:  mode = f.near_active ? MODE_MEAN : MODE_ONE;
    endcase
    o.rho_ratio   = ONE_Q24;
    o.visc_ratio  = ONE_Q24;
    o.denom_error = 1'b0;
    if (mode == MODE_MEAN) begin
      o.rho_ratio   = 32'((nr + fr + 1) >>> 1);
      o.visc_ratio  = 32'((nv + fv + 1) >>> 1);
      o.denom_error = nb || fb;
    end else if (mode == MODE_FAR) begin
      o.rho_ratio   = 32'(fr);
      o.visc_ratio  = 32'(fv);
      o.denom_error = fb;
    end
    if (o.denom_error) o.visc_ratio = SAT_MAX;
    return o;
  endfunction

  always @(posedge clk_i) begin
    dvfr_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_ratios.size() == 0) begin
        $error("result with no face outstanding");
        fail_count++;
      end else begin
        want = expected_ratios.pop_front();
        if (result_o.rho_ratio !== want.rho_ratio) begin
          $error("rho_ratio: expected %h, got %h", want.rho_ratio, result_o.rho_ratio);
          fail_count++;
        end
        if (result_o.visc_ratio !== want.visc_ratio) begin
          $error("visc_ratio: expected %h, got %h", want.visc_ratio, result_o.visc_ratio);
          fail_count++;
        end
        if (result_o.denom_error !== want.denom_error) begin
          $error("denom_error: expected %b, got %b", want.denom_error,
                 result_o.denom_error);
          fail_count++;
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_BETA_S:  cfg_beta_s  = longint'($signed(data));
      REG_BETA_SV: cfg_beta_sv = longint'($signed(data));
      REG_BETA_T:  cfg_beta_t  = longint'($signed(data));
      REG_REF_T:   cfg_ref_t   = longint'($signed(data));
      REG_SAL_ON:  cfg_sal_on  = data[0];
      REG_THM_ON:  cfg_thm_on  = data[0];
      default: ;
    endcase
  endtask

  task automatic apb_check(logic [2:0] idx, logic [31:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("prdata: expected %h, got %h", want, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Registers only change once the pipeline has emptied.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    wait (expected_ratios.size() == 0);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] bs, logic [31:0] bsv, logic [31:0] bt,
                           logic [31:0] rt, bit sal_on, bit thm_on);
    drain();
    apb_write(REG_BETA_S, bs);
    apb_write(REG_BETA_SV, bsv);
    apb_write(REG_BETA_T, bt);
    apb_write(REG_REF_T, rt);
    apb_write(REG_SAL_ON, {31'($urandom), sal_on});
    apb_write(REG_THM_ON, {31'($urandom), thm_on});
  endtask

  task automatic send_face(dvfr_in_t f, int gap);
    @(negedge clk_i);
    start  = 1'b1;
    face_i = f;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    expected_ratios.push_back(predict_face_ratio(f));
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_scalar();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0: return r;
      1: return {{10{r[21]}}, r[21:0]};
      2: return {{14{r[17]}}, r[17:0]};
      3: return r & 32'h000F_FFFF;
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0001_0000;
          3: return 32'hFFFF_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: return r;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  function automatic dvfr_in_t rand_face();
    dvfr_in_t f;
    f.req_type      = 2'($urandom);
    f.near_active   = ($urandom_range(9) != 0);
    f.far_active    = ($urandom_range(9) != 0);
    f.head_bc       = 1'($urandom);
    f.near_salinity = rand_scalar();
    f.near_temp     = rand_scalar();
    f.far_salinity  = rand_scalar();
    f.far_temp      = rand_scalar();
    return f;
  endfunction

  function automatic dvfr_in_t make_face(logic [1:0] kind, bit na, bit fa, bit hb,
                                         logic [31:0] ns, logic [31:0] nt,
                                         logic [31:0] fs, logic [31:0] ft);
    dvfr_in_t f;
    f.req_type      = kind;
    f.near_active   = na;
    f.far_active    = fa;
    f.head_bc       = hb;
    f.near_salinity = ns;
    f.near_temp     = nt;
    f.far_salinity  = fs;
    f.far_temp      = ft;
    return f;
  endfunction

  task automatic test_register_access();
    apb_check(REG_BETA_S, 32'h0);
    apb_check(REG_SAL_ON, 32'h1);
    apb_check(REG_THM_ON, 32'h0);
    configure(32'h0080_0000, 32'h0040_0000, 32'h0020_0000, 32'h0014_0000, 1'b1, 1'b1);
    apb_check(REG_BETA_S, 32'h0080_0000);
    apb_check(REG_BETA_SV, 32'h0040_0000);
    apb_check(REG_BETA_T, 32'h0020_0000);
    apb_check(REG_REF_T, 32'h0014_0000);
    // Addresses past the last register must not disturb any register.
    apb_write(3'd6, 32'hDEAD_BEEF);
    apb_write(3'd7, 32'h1234_5678);
    apb_check(REG_BETA_S, 32'h0080_0000);
    apb_check(REG_REF_T, 32'h0014_0000);
  endtask

  task automatic test_face_rules();
    logic [1:0] kind;
    for (int k = 0; k < 4; k++) begin
      kind = 2'(k);
      for (int m = 0; m < 4; m++)
        send_face(make_face(kind, m[1], m[0], m[0] ^ m[1], 32'h0002_0000,
                            32'h0019_0000, 32'hFFFF_8000, 32'h000A_0000),
                  $urandom_range(2));
      send_face(make_face(kind, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF), 0);
    end
  endtask

  task automatic test_bad_denominator();
    // Viscosity coefficient of minus one: salinity one gives a zero
    // denominator, larger salinity a negative one.
    configure(32'h0010_0000, 32'hFF00_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    send_face(make_face(REQ_PAIR, 1'b1, 1'b1, 1'b0, 32'h0001_0000, 32'h0,
                        32'h0, 32'h0), 0);
    send_face(make_face(REQ_LOW, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0,
                        32'h0002_0000, 32'h0), 0);
    send_face(make_face(REQ_HIGH, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0,
                        32'h0000_0001, 32'h0), 0);
    // A tiny positive denominator: the reciprocal saturates without an error.
    send_face(make_face(REQ_TOP, 1'b1, 1'b0, 1'b0, 32'h0000_FFFF, 32'h0,
                        32'h0, 32'h0), 0);
    send_face(make_face(REQ_HIGH, 1'b0, 1'b1, 1'b1, 32'h0001_0000, 32'h0,
                        32'h0001_0000, 32'h0), 3);
  endtask

  task automatic random_phase(int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0) burst_mode = ~burst_mode;
      gap = burst_mode ? 0 : $urandom_range(14);
      if (i == count / 3) drain();
      send_face(rand_face(), gap);
    end
  endtask

  task automatic test_random_settings();
    configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    random_phase(160);
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    random_phase(160);
    configure(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    random_phase(60);
    for (int p = 0; p < 6; p++) begin
      configure(rand_coef(), rand_coef(), rand_coef(), rand_scalar(),
                1'($urandom), ($urandom_range(3) != 0));
      random_phase(150);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    face_i      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    cycle_count = 0;
    burst_mode  = 1'b0;
    cfg_beta_s  = 0;
    cfg_beta_sv = 0;
    cfg_beta_t  = 0;
    cfg_ref_t   = 0;
    cfg_sal_on  = 1'b1;
    cfg_thm_on  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // A few faces on the reset settings first.
    send_face(make_face(REQ_PAIR, 1'b1, 1'b1, 1'b0, 32'h0003_0000, 32'h0,
                        32'h0, 32'h0), 0);
    send_face(make_face(REQ_LOW, 1'b1, 1'b1, 1'b1, 32'h0, 32'h0,
                        32'h0005_0000, 32'h0), 1);
    test_register_access();
    test_face_rules();
    test_bad_denominator();
    test_random_settings();

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** density_viscosity_face_ratio: PASSED **");
    end else begin
      $display("** density_viscosity_face_ratio: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/dvfr_pkg.sv
src/density_viscosity_face_ratio.sv
tb/testbench.sv
